FILE: sv/lngh_pkg.sv
// ----------------------------------------------------------------------------
// lngh_pkg
// Shared types and constants of the letter n-gram histogram: table sizes,
// field widths, request codes and the command passed from front to back.
// ----------------------------------------------------------------------------
package lngh_pkg;

	// alphabet and table sizes
	localparam int ALPHA     = 26;
	localparam int BI_DEPTH  = ALPHA * ALPHA;
	localparam int TRI_DEPTH = ALPHA * ALPHA * ALPHA;

	// field widths
	localparam int LETTER_W = 5;
	localparam int BI_AW    = $clog2(BI_DEPTH);
	localparam int TRI_AW   = $clog2(TRI_DEPTH);
	localparam int ORDER_W  = 2;
	localparam int INDEX_W  = 15;
	localparam int BYTE_W   = 8;
	localparam int OUT_W    = 32;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 2 * OUT_W;

	// default counter width
	localparam int COUNT_WIDTH_DEF = 32;

	// command queue depth (power of two)
	localparam int QUEUE_DEPTH = 4;

	// request kinds on tuser
	localparam logic REQ_TEXT = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// gram orders
	localparam logic [ORDER_W-1:0] ORD_UNI = 2'd1;
	localparam logic [ORDER_W-1:0] ORD_BI  = 2'd2;
	localparam logic [ORDER_W-1:0] ORD_TRI = 2'd3;

	// character bounds
	localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7a;
	localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5a;

	typedef enum logic {
		OP_COUNT,
		OP_READ
	} cmd_op_t;

	// one queued command
	typedef struct packed {
		cmd_op_t              op;
		logic [LETTER_W-1:0]  letter;
		logic                 bi_en;
		logic                 tri_en;
		logic [BI_AW-1:0]     bi_addr;
		logic [TRI_AW-1:0]    tri_addr;
		logic [ORDER_W-1:0]   rd_order;
		logic [INDEX_W-1:0]   rd_index;
	} cmd_t;

	// back-end status seen by the front
	typedef struct packed {
		logic clr_busy;
	} back_stat_t;

endpackage

FILE: sv/lngh_queue.sv
// ----------------------------------------------------------------------------
// lngh_queue
// Short command queue between the front classifier and the table back end.
// ----------------------------------------------------------------------------
module lngh_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lngh_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          valid,
	output lngh_pkg::cmd_t head
);
	import lngh_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full  = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign valid = (fill_q != '0);
	assign head  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/lngh_front.sv
// ----------------------------------------------------------------------------
// lngh_front
// Accepts input beats, folds letters, tracks the current word and forms the
// table addresses for each counted letter, or passes on the read fields of a read request.
// ----------------------------------------------------------------------------
module lngh_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lngh_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,
	input  lngh_pkg::back_stat_t            back_stat,
	input  logic                            q_full,
	output logic                            push,
	output lngh_pkg::cmd_t                  push_cmd
);
	import lngh_pkg::*;

	logic [BYTE_W-1:0]   text_byte;
	logic [ORDER_W-1:0]  gram_order;
	logic [INDEX_W-1:0]  gram_index;
	logic                is_lower;
	logic                is_upper;
	logic                is_letter;
	logic [LETTER_W-1:0] letter;
	logic [BI_AW-1:0]    bi_addr;
	logic [TRI_AW-1:0]   tri_addr;
	logic                accept;

	logic [LETTER_W-1:0] prev_q;
	logic [BI_AW-1:0]    pair_q;
	logic [1:0]          run_len_q;

	// field unpacking
	assign text_byte  = s_tdata[BYTE_W-1:0];
	assign gram_order = s_tdata[BYTE_W+ORDER_W-1:BYTE_W];
	assign gram_index = s_tdata[BYTE_W+ORDER_W+INDEX_W-1:BYTE_W+ORDER_W];

	assign s_tready = !q_full && !back_stat.clr_busy;
	assign accept   = s_tvalid && s_tready;

	// letter fold
	always_comb begin
		is_lower  = (text_byte >= CH_LOWER_A) && (text_byte <= CH_LOWER_Z);
		is_upper  = (text_byte >= CH_UPPER_A) && (text_byte <= CH_UPPER_Z);
		is_letter = is_lower || is_upper;
		if (is_lower) begin
			letter = LETTER_W'(text_byte - CH_LOWER_A);
		end else begin
			letter = LETTER_W'(text_byte - CH_UPPER_A);
		end
	end

	// gram addresses ending at this letter
	assign bi_addr  = BI_AW'(prev_q) * BI_AW'(ALPHA) + BI_AW'(letter);
	assign tri_addr = TRI_AW'(pair_q) * TRI_AW'(ALPHA) + TRI_AW'(letter);

	// command build
	always_comb begin
		push_cmd          = '0;
		push_cmd.letter   = letter;
		push_cmd.bi_en    = (run_len_q != 2'd0);
		push_cmd.tri_en   = (run_len_q == 2'd2);
		push_cmd.bi_addr  = bi_addr;
		push_cmd.tri_addr = tri_addr;
		push_cmd.rd_order = gram_order;
		push_cmd.rd_index = gram_index;
		if (s_tuser == REQ_READ) begin
			push_cmd.op = OP_READ;
		end else begin
			push_cmd.op = OP_COUNT;
		end
		push = accept && ((s_tuser == REQ_READ) || is_letter);
	end

	// word tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			pair_q    <= '0;
			run_len_q <= '0;
		end else if (accept && (s_tuser == REQ_TEXT)) begin
			if (is_letter) begin
				prev_q <= letter;
				pair_q <= bi_addr;
				if (run_len_q != 2'd2) begin
					run_len_q <= run_len_q + 1'b1;
				end
			end else begin
				run_len_q <= '0;
			end
		end
	end

endmodule

FILE: sv/lngh_back.sv
// ----------------------------------------------------------------------------
// lngh_back
// Table back end: clears the gram memories after reset, then runs each
// queued command as a read-modify-write or a lookup into the output register.
// ----------------------------------------------------------------------------
module lngh_back #(
	parameter int COUNT_WIDTH = lngh_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  lngh_pkg::cmd_t                head,
	output logic                          pop,
	output lngh_pkg::back_stat_t          back_stat,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lngh_pkg::M_DATA_W-1:0] m_tdata
);
	import lngh_pkg::*;

	localparam int CLR_W = $clog2(TRI_DEPTH);
	localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(TRI_DEPTH - 1);

	typedef enum logic [1:0] {
		ST_CLR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// saturating increment
	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + COUNT_WIDTH'(1);
	endfunction

	// clamp to the 32-bit result field
	function automatic logic [OUT_W-1:0] clamp_out(input logic [COUNT_WIDTH-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (|w[63:OUT_W]) ? '1 : w[OUT_W-1:0];
	endfunction

	state_t                 state_q;
	cmd_t                   cmd_q;
	logic [CLR_W-1:0]       clr_idx_q;
	logic [COUNT_WIDTH-1:0] uni_q   [ALPHA];
	logic [COUNT_WIDTH-1:0] total_q [3];
	logic                   m_tvalid_q;
	logic [M_DATA_W-1:0]    m_tdata_q;

	logic [COUNT_WIDTH-1:0] bi_mem  [BI_DEPTH];
	logic [COUNT_WIDTH-1:0] tri_mem [TRI_DEPTH];
	logic [COUNT_WIDTH-1:0] bi_rd_q;
	logic [COUNT_WIDTH-1:0] tri_rd_q;

	logic                   mem_re;
	logic [BI_AW-1:0]       bi_raddr;
	logic [TRI_AW-1:0]      tri_raddr;
	logic                   bi_we;
	logic                   tri_we;
	logic [BI_AW-1:0]       bi_waddr;
	logic [TRI_AW-1:0]      tri_waddr;
	logic [COUNT_WIDTH-1:0] bi_wdata;
	logic [COUNT_WIDTH-1:0] tri_wdata;

	logic [LETTER_W-1:0]    uni_addr;
	logic [COUNT_WIDTH-1:0] uni_rd;
	logic [COUNT_WIDTH-1:0] rd_count;
	logic [COUNT_WIDTH-1:0] rd_total;
	logic                   out_free;
	logic                   out_load;

	assign pop                = (state_q == ST_IDLE) && q_valid;
	assign mem_re             = pop;
	assign back_stat.clr_busy = (state_q == ST_CLR);
	assign m_tvalid           = m_tvalid_q;
	assign m_tdata            = m_tdata_q;
	assign out_free           = !m_tvalid_q || m_tready;
	assign out_load           = (state_q == ST_EXEC) && (cmd_q.op == OP_READ) && out_free;

	// read addresses from the queue head
	always_comb begin
		if (head.op == OP_COUNT) begin
			bi_raddr  = head.bi_addr;
			tri_raddr = head.tri_addr;
		end else begin
			bi_raddr  = head.rd_index[BI_AW-1:0];
			tri_raddr = head.rd_index[TRI_AW-1:0];
		end
	end

	// write ports: clearing pass or counter update
	always_comb begin
		bi_we     = 1'b0;
		tri_we    = 1'b0;
		bi_waddr  = cmd_q.bi_addr;
		tri_waddr = cmd_q.tri_addr;
		bi_wdata  = sat_inc(bi_rd_q);
		tri_wdata = sat_inc(tri_rd_q);
		if (state_q == ST_CLR) begin
			bi_we     = (clr_idx_q < CLR_W'(BI_DEPTH));
			tri_we    = 1'b1;
			bi_waddr  = clr_idx_q[BI_AW-1:0];
			tri_waddr = clr_idx_q[TRI_AW-1:0];
			bi_wdata  = '0;
			tri_wdata = '0;
		end else if ((state_q == ST_EXEC) && (cmd_q.op == OP_COUNT)) begin
			bi_we  = cmd_q.bi_en;
			tri_we = cmd_q.tri_en;
		end
	end

	// gram memories
	always_ff @(posedge clk) begin
		if (bi_we) begin
			bi_mem[bi_waddr] <= bi_wdata;
		end
		if (tri_we) begin
			tri_mem[tri_waddr] <= tri_wdata;
		end
		if (mem_re) begin
			bi_rd_q  <= bi_mem[bi_raddr];
			tri_rd_q <= tri_mem[tri_raddr];
		end
	end

	// unigram port, one address
	assign uni_addr = (cmd_q.op == OP_READ) ? cmd_q.rd_index[LETTER_W-1:0] : cmd_q.letter;
	assign uni_rd   = uni_q[uni_addr];

	// lookup result
	always_comb begin
		rd_count = '0;
		rd_total = '0;
		case (cmd_q.rd_order)
			ORD_UNI: begin
				rd_total = total_q[0];
				if (cmd_q.rd_index < INDEX_W'(ALPHA)) begin
					rd_count = uni_rd;
				end
			end
			ORD_BI: begin
				rd_total = total_q[1];
				if (cmd_q.rd_index < INDEX_W'(BI_DEPTH)) begin
					rd_count = bi_rd_q;
				end
			end
			ORD_TRI: begin
				rd_total = total_q[2];
				if (cmd_q.rd_index < INDEX_W'(TRI_DEPTH)) begin
					rd_count = tri_rd_q;
				end
			end
			default: begin
				rd_count = '0;
				rd_total = '0;
			end
		endcase
	end

	// sequencer, unigram and total counters, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			cmd_q      <= '0;
			clr_idx_q  <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			for (int i = 0; i < ALPHA; i++) begin
				uni_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				total_q[i] <= '0;
			end
		end else begin
			// output valid: set by a finished read, dropped by the accepted beat
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						cmd_q   <= head;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd_q.op == OP_COUNT) begin
						uni_q[uni_addr] <= sat_inc(uni_rd);
						total_q[0]      <= sat_inc(total_q[0]);
						if (cmd_q.bi_en) begin
							total_q[1] <= sat_inc(total_q[1]);
						end
						if (cmd_q.tri_en) begin
							total_q[2] <= sat_inc(total_q[2]);
						end
						state_q <= ST_IDLE;
					end else if (out_free) begin
						m_tdata_q  <= {clamp_out(rd_total), clamp_out(rd_count)};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/letter_ngram_histogram.sv
// ----------------------------------------------------------------------------
// letter_ngram_histogram
// Counts letter unigrams, bigrams and trigrams of a text byte stream within
// words, with per-order totals, and answers single-count read requests.
//
//   channel  dir  tdata                                         tuser
//   s_*      in   text_byte, gram_order, gram_index             req_type
//   m_*      out  count_value, total_value                      -
//
// The front takes one beat per cycle into a four-entry command queue, while the
// queue has room and no clear runs. The back runs one command at a time: a read
// of the gram memories, then the saturating write-back or the load of the output
// register. Non-letter text beats end the word in the front and reach the back
// not at all. After reset the back clears the bigram and trigram memories with
// s_tready low. A read waits in the back while the output beat is held.
// ----------------------------------------------------------------------------
module letter_ngram_histogram #(
	parameter int COUNT_WIDTH = lngh_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [7:0] text_byte, [9:8] gram_order, [24:10] gram_index, rest zero
	input  logic [lngh_pkg::S_DATA_W-1:0] s_tdata,
	// [0] req_type
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] count_value, [63:32] total_value
	output logic [lngh_pkg::M_DATA_W-1:0] m_tdata
);
	import lngh_pkg::*;

	back_stat_t back_stat;
	logic       q_full;
	logic       q_valid;
	logic       push;
	logic       pop;
	cmd_t       push_cmd;
	cmd_t       head;

	// classifier
	lngh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.back_stat (back_stat),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// command queue
	lngh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.valid    (q_valid),
		.head     (head)
	);

	// table back end
	lngh_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop),
		.back_stat (back_stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

FILE: tb/sv/letter_ngram_histogram_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_ngram_histogram_checker
// Watches both stream channels of the n-gram histogram. Every accepted text
// beat updates a shadow set of unigram, bigram and trigram tables; every
// accepted read beat queues the count and order total it should return. Each
// result beat is compared field by field with the oldest queued readout.
// ----------------------------------------------------------------------------
module letter_ngram_histogram_checker
	import lngh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	// [7:0] text_byte, [9:8] gram_order, [24:10] gram_index, rest zero
	input  logic [S_DATA_W-1:0] s_tdata,
	// [0] req_type
	input  logic                s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	// [31:0] count_value, [63:32] total_value
	input  logic [M_DATA_W-1:0] m_tdata,
	output int                  fail_count,
	output int                  pending
);

	localparam int COUNT_W  = COUNT_WIDTH_DEF;
	localparam int REPORT_N = 10;

	typedef logic [COUNT_W-1:0] cnt_t;

	typedef struct {
		logic [OUT_W-1:0] count;
		logic [OUT_W-1:0] total;
	} readout_t;

	// shadow histogram state
	cnt_t                uni_tab [ALPHA];
	cnt_t                bi_tab  [BI_DEPTH];
	cnt_t                tri_tab [TRI_DEPTH];
	cnt_t                order_sum [3];
	logic [LETTER_W-1:0] last_ltr;
	logic [LETTER_W-1:0] older_ltr;
	logic [1:0]          run_len;

	readout_t due_readouts [$];
	int       shown = 0;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// counters stick at all ones
	function automatic cnt_t sat_bump(input cnt_t c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	// fold case, end the word on a non-letter, count the grams ending here
	task automatic track_text_byte(input logic [BYTE_W-1:0] ch);
		logic [LETTER_W-1:0] ltr;
		if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			ltr = LETTER_W'(ch - CH_LOWER_A);
		end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			ltr = LETTER_W'(ch - CH_UPPER_A);
		end else begin
			run_len = 2'd0;
			return;
		end
		uni_tab[ltr] = sat_bump(uni_tab[ltr]);
		order_sum[0] = sat_bump(order_sum[0]);
		if (run_len >= 2'd1) begin
			bi_tab[last_ltr * ALPHA + ltr] = sat_bump(bi_tab[last_ltr * ALPHA + ltr]);
			order_sum[1] = sat_bump(order_sum[1]);
		end
		if (run_len >= 2'd2) begin
			tri_tab[(older_ltr * ALPHA + last_ltr) * ALPHA + ltr] =
				sat_bump(tri_tab[(older_ltr * ALPHA + last_ltr) * ALPHA + ltr]);
			order_sum[2] = sat_bump(order_sum[2]);
		end
		older_ltr = last_ltr;
		last_ltr  = ltr;
		if (run_len < 2'd2)
			run_len = run_len + 2'd1;
	endtask

	// count and total that a read beat should return
	function automatic readout_t gram_lookup(input logic [ORDER_W-1:0] ord,
	                                         input logic [INDEX_W-1:0] idx);
		readout_t r;
		r.count = '0;
		r.total = '0;
		case (ord)
			ORD_UNI: begin
				r.total = order_sum[0];
				if (idx < ALPHA)
					r.count = uni_tab[idx];
			end
			ORD_BI: begin
				r.total = order_sum[1];
				if (idx < BI_DEPTH)
					r.count = bi_tab[idx];
			end
			ORD_TRI: begin
				r.total = order_sum[2];
				if (idx < TRI_DEPTH)
					r.count = tri_tab[idx];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic note_mismatch(input string field, input logic [OUT_W-1:0] want,
	                             input logic [OUT_W-1:0] got);
		fail_count++;
		if (shown < REPORT_N) begin
			$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
			shown++;
		end
	endtask

	// result beats first, then the input beat of the same edge
	always @(posedge clk or negedge arst_n) begin
		readout_t want;
		if (!arst_n) begin
			foreach (uni_tab[i]) uni_tab[i] = '0;
			foreach (bi_tab[i]) bi_tab[i] = '0;
			foreach (tri_tab[i]) tri_tab[i] = '0;
			foreach (order_sum[i]) order_sum[i] = '0;
			last_ltr  = '0;
			older_ltr = '0;
			run_len   = '0;
			due_readouts.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_readouts.size() == 0) begin
					fail_count++;
					if (shown < REPORT_N) begin
						$display("%0t result beat with none pending: count %0d total %0d",
							$realtime, m_tdata[OUT_W-1:0], m_tdata[M_DATA_W-1:OUT_W]);
						shown++;
					end
				end else begin
					want = due_readouts.pop_front();
					if (m_tdata[OUT_W-1:0] !== want.count)
						note_mismatch("count_value", want.count, m_tdata[OUT_W-1:0]);
					if (m_tdata[M_DATA_W-1:OUT_W] !== want.total)
						note_mismatch("total_value", want.total, m_tdata[M_DATA_W-1:OUT_W]);
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == REQ_READ)
					due_readouts.insert(due_readouts.size(),
						gram_lookup(s_tdata[9:8], s_tdata[24:10]));
				else
					track_text_byte(s_tdata[7:0]);
			end
		end
		pending = due_readouts.size();
	end

endmodule

FILE: tb/sv/tb_letter_ngram_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_letter_ngram_histogram
// Drives text and read beats into the n-gram histogram: a directed opening on
// character boundaries, range limits and word handling, then random words
// over a narrow alphabet mixed with reads and noise. Both channels idle at
// random. The checker beside the block predicts and compares the readouts.
// ----------------------------------------------------------------------------
module tb_letter_ngram_histogram;
	import lngh_pkg::*;

	localparam int RANDOM_ITEMS = 650;
	localparam int IDLE_LIMIT   = 90000;
	localparam int TAIL_CYCLES  = 16;
	localparam int MAX_GAP      = 10;
	localparam logic [ORDER_W-1:0] ORD_NONE = 2'd0;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic                s_tuser  = REQ_TEXT;
	logic                m_tready = 1'b0;
	logic                s_tready;
	logic                m_tvalid;
	logic [M_DATA_W-1:0] m_tdata;

	int fail_count;
	int pending;
	int idle_cycles = 0;
	int beats_sent  = 0;
	bit tx_calm     = 1'b0;
	bit rx_calm     = 1'b0;

	always #2 clk = ~clk;

	letter_ngram_histogram u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	letter_ngram_histogram_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// cycles since the last beat on either channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// result side: random stall before each beat, calm stretches now and then
	initial begin
		int gap;
		int taken;
		taken = 0;
		@(posedge clk);
		forever begin
			gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
			if (taken % 32 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
		end
	end

	task automatic send_beat(input logic req, input logic [BYTE_W-1:0] ch,
	                         input logic [ORDER_W-1:0] ord, input logic [INDEX_W-1:0] idx);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= S_DATA_W'({idx, ord, ch});
		do @(posedge clk); while (!s_tready);
		beats_sent++;
		if (beats_sent % 40 == 0)
			tx_calm = ($urandom_range(0, 3) == 0);
	endtask

	// text beat with junk in the unused read fields
	task automatic send_text(input logic [BYTE_W-1:0] ch);
		send_beat(REQ_TEXT, ch, ORDER_W'($urandom), INDEX_W'($urandom));
	endtask

	task automatic send_read(input logic [ORDER_W-1:0] ord, input logic [INDEX_W-1:0] idx);
		send_beat(REQ_READ, BYTE_W'($urandom), ord, idx);
	endtask

	function automatic bit is_letter(input logic [BYTE_W-1:0] ch);
		return (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) || (ch >= CH_UPPER_A && ch <= CH_UPPER_Z);
	endfunction

	// mostly a..e so that reads land on grams that were counted
	function automatic int pick_letter();
		return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, ALPHA - 1);
	endfunction

	function automatic logic [BYTE_W-1:0] letter_byte(input int ltr);
		return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + BYTE_W'(ltr);
	endfunction

	task automatic send_separator();
		logic [BYTE_W-1:0] ch;
		do ch = BYTE_W'($urandom); while (is_letter(ch));
		send_text(ch);
	endtask

	// read of a likely gram, any in-range gram, or any index at all
	task automatic send_random_read();
		logic [ORDER_W-1:0] ord;
		logic [INDEX_W-1:0] idx;
		int pick;
		ord  = ($urandom_range(0, 9) == 0) ? ORD_NONE : ORDER_W'($urandom_range(1, 3));
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			case (ord)
				ORD_UNI: idx = INDEX_W'(pick_letter());
				ORD_BI:  idx = INDEX_W'(pick_letter() * ALPHA + pick_letter());
				default: idx = INDEX_W'((pick_letter() * ALPHA + pick_letter()) * ALPHA
					+ pick_letter());
			endcase
		end else if (pick < 85) begin
			case (ord)
				ORD_UNI: idx = INDEX_W'($urandom_range(0, ALPHA - 1));
				ORD_BI:  idx = INDEX_W'($urandom_range(0, BI_DEPTH - 1));
				default: idx = INDEX_W'($urandom_range(0, TRI_DEPTH - 1));
			endcase
		end else begin
			idx = INDEX_W'($urandom);
		end
		send_read(ord, idx);
	endtask

	task automatic send_random_word();
		int len;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 5);
		for (int i = 0; i < len; i++) begin
			send_text(letter_byte(pick_letter()));
			if ($urandom_range(0, 7) == 0)
				send_random_read();
		end
		if ($urandom_range(0, 9) != 0)
			send_separator();
	endtask

	initial begin
		int pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty tables read back zero
		send_read(ORD_UNI, 15'd0);
		// letter bounds of both cases, one word "azza"
		send_text(CH_UPPER_A);
		send_text(CH_LOWER_Z);
		send_text(CH_UPPER_Z);
		send_text(CH_LOWER_A);
		// bytes just outside the letter ranges, and the top byte, end words
		send_text(CH_UPPER_A - 8'd1);
		send_text(CH_UPPER_Z + 8'd1);
		send_text(CH_LOWER_A - 8'd1);
		send_text(CH_LOWER_Z + 8'd1);
		send_text(8'hff);
		send_read(ORD_BI, 15'd25);
		// a read in the middle of a word leaves the word intact
		send_text(CH_LOWER_A + 8'd1);
		send_text(CH_LOWER_A + 8'd2);
		send_read(ORD_TRI, 15'd675);
		send_text(CH_UPPER_A + 8'd3);
		send_read(ORD_TRI, 15'd731);
		// index one past each table, and the top index
		send_read(ORD_UNI, 15'(ALPHA));
		send_read(ORD_BI, 15'(BI_DEPTH));
		send_read(ORD_TRI, 15'(TRI_DEPTH));
		send_read(ORD_TRI, 15'h7fff);
		// order zero reads zero for both fields
		send_read(ORD_NONE, 15'd0);
		send_read(ORD_NONE, 15'h7fff);
		// trailing word with no terminator is already counted
		send_text(CH_LOWER_A + 8'd23);
		send_text(CH_LOWER_A + 8'd24);
		send_read(ORD_BI, 15'd622);

		// random: mostly words, some reads, a little noise
		while (beats_sent < RANDOM_ITEMS + 25) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				send_random_word();
			else if (pick < 88)
				send_random_read();
			else
				send_beat(1'($urandom), BYTE_W'($urandom), ORDER_W'($urandom),
					INDEX_W'($urandom));
		end
		s_tvalid <= 1'b0;

		// let the checker take in the last accepted beat
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
sv/lngh_pkg.sv
sv/lngh_queue.sv
sv/lngh_front.sv
sv/lngh_back.sv
sv/letter_ngram_histogram.sv
tb/sv/letter_ngram_histogram_checker.sv
tb/sv/tb_letter_ngram_histogram.sv
